// ===== hdl/mm_pkg.sv =====
// Shared constants, types and helpers for the matrix multiply block.
package mm_pkg;

  localparam int MAX_DIM     = 8;
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int IDX_W       = $clog2(MAX_DIM);
  localparam int DIM_W       = 4;
  localparam int VALUE_W     = 16;
  localparam int MUL_W       = 2 * VALUE_W;
  localparam int PROD_W      = 36;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B     = 2'd2;

  localparam logic ACTION_LEFT  = 1'b0;
  localparam logic ACTION_RIGHT = 1'b1;

  typedef struct packed {
    logic load;
    logic start_pass;
    logic issue;
    logic advance;
  } mm_cmd_t;

  typedef struct packed {
    logic pass_full;
    logic t_last;
    logic elem_last;
    logic result_landed;
    logic out_free;
  } mm_status_t;

  function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] r);
    logic [DIM_W-1:0] s;
    s = r;
    if (r == '0) begin
      s = DIM_W'(1);
    end else if (r > DIM_W'(MAX_DIM)) begin
      s = DIM_W'(MAX_DIM);
    end
    return s;
  endfunction

endpackage

// ===== hdl/mm_interfaces.sv =====
// Request and result channel interfaces for the matrix multiply block.
interface mm_in_if import mm_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface mm_out_if import mm_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [PROD_W-1:0] product;
  logic [IDX_W-1:0]         out_row;
  logic [IDX_W-1:0]         out_col;
  logic                     last;

  modport source (output valid, output product, output out_row, output out_col, output last,
                  input ready);
  modport sink   (input valid, input product, input out_row, input out_col, input last,
                  output ready);
endinterface

// ===== hdl/mm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/mm_controller.sv =====
// Sequencer for loading, per-element dot product issue and result hand-off.
module mm_controller import mm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output mm_cmd_t    cmd,
  input  mm_status_t status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_START,
    S_ISSUE,
    S_DRAIN
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.pass_full) begin
            state_next = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        cmd.start_pass = 1'b1;
        state_next     = S_START;
      end
      S_START: begin
        if (status.out_free) begin
          state_next = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.issue = 1'b1;
        if (status.t_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (status.result_landed) begin
          if (status.elem_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.advance = 1'b1;
            state_next  = S_START;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/mm_datapath.sv =====
// Size registers, element stores, address walk, multiply-accumulate and result register.
module mm_datapath import mm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [DIM_W-1:0]          cfg_data,
  input  logic                      action,
  input  logic signed [VALUE_W-1:0] value,
  input  mm_cmd_t                   cmd,
  output mm_status_t                status,
  mm_out_if.source                  result
);

  logic [DIM_W-1:0] rows_a;
  logic [DIM_W-1:0] inner_size;
  logic [DIM_W-1:0] cols_b;

  logic [DIM_W-1:0] m_cfg;
  logic [DIM_W-1:0] k_cfg;
  logic [DIM_W-1:0] n_cfg;
  logic [CNT_W-1:0] left_size;
  logic [CNT_W-1:0] right_size;

  logic [CNT_W-1:0] left_count;
  logic [CNT_W-1:0] right_count;
  logic [CNT_W-1:0] left_count_next;
  logic [CNT_W-1:0] right_count_next;
  logic             write_left;
  logic             write_right;

  logic [DIM_W-1:0]  m_run;
  logic [DIM_W-1:0]  k_run;
  logic [DIM_W-1:0]  n_run;
  logic [IDX_W-1:0]  i;
  logic [IDX_W-1:0]  j;
  logic [IDX_W-1:0]  t;
  logic [ADDR_W-1:0] row_base;
  logic [ADDR_W-1:0] row_base_next;
  logic [ADDR_W-1:0] a_ptr;
  logic [ADDR_W-1:0] b_ptr;
  logic              i_last;
  logic              j_last;
  logic              t_last;

  logic [VALUE_W-1:0] left_rd;
  logic [VALUE_W-1:0] right_rd;

  logic              s1_valid;
  logic              s1_first;
  logic              s1_tlast;
  logic              s1_elast;
  logic [IDX_W-1:0]  s1_row;
  logic [IDX_W-1:0]  s1_col;

  logic              s2_valid;
  logic              s2_first;
  logic              s2_tlast;
  logic              s2_elast;
  logic [IDX_W-1:0]  s2_row;
  logic [IDX_W-1:0]  s2_col;
  logic signed [MUL_W-1:0] s2_prod;

  logic [PROD_W-1:0] acc;
  logic [PROD_W-1:0] acc_base;
  logic [PROD_W-1:0] prod_ext;
  logic [PROD_W-1:0] acc_sum;
  logic              landed;

  logic              out_valid;
  logic [PROD_W-1:0] out_product;
  logic [IDX_W-1:0]  out_row;
  logic [IDX_W-1:0]  out_col;
  logic              out_last;

  // Size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a     <= DIM_W'(1);
      inner_size <= DIM_W'(1);
      cols_b     <= DIM_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_ROWS_A:     rows_a     <= cfg_data;
        REG_INNER_SIZE: inner_size <= cfg_data;
        REG_COLS_B:     cols_b     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign m_cfg      = eff_size(rows_a);
  assign k_cfg      = eff_size(inner_size);
  assign n_cfg      = eff_size(cols_b);
  assign left_size  = CNT_W'(m_cfg) * CNT_W'(k_cfg);
  assign right_size = CNT_W'(k_cfg) * CNT_W'(n_cfg);

  // Loading
  assign write_left  = cmd.load && (action == ACTION_LEFT) && (left_count < left_size);
  assign write_right = cmd.load && (action == ACTION_RIGHT) && (right_count < right_size);
  assign left_count_next  = left_count + CNT_W'(write_left);
  assign right_count_next = right_count + CNT_W'(write_right);
  assign status.pass_full = (left_count_next >= left_size) && (right_count_next >= right_size);

  always_ff @(posedge clk) begin
    if (rst) begin
      left_count  <= '0;
      right_count <= '0;
    end else if (cmd.start_pass) begin
      left_count  <= '0;
      right_count <= '0;
    end else begin
      left_count  <= left_count_next;
      right_count <= right_count_next;
    end
  end

  mm_ram #(.WIDTH(VALUE_W), .DEPTH(STORE_DEPTH)) left_ram (
    .clk   (clk),
    .we    (write_left),
    .waddr (left_count[ADDR_W-1:0]),
    .wdata (value),
    .raddr (a_ptr),
    .rdata (left_rd)
  );

  mm_ram #(.WIDTH(VALUE_W), .DEPTH(STORE_DEPTH)) right_ram (
    .clk   (clk),
    .we    (write_right),
    .waddr (right_count[ADDR_W-1:0]),
    .wdata (value),
    .raddr (b_ptr),
    .rdata (right_rd)
  );

  // Address walk
  assign i_last        = (DIM_W'(i) == m_run - DIM_W'(1));
  assign j_last        = (DIM_W'(j) == n_run - DIM_W'(1));
  assign t_last        = (DIM_W'(t) == k_run - DIM_W'(1));
  assign row_base_next = row_base + ADDR_W'(k_run);

  assign status.t_last    = t_last;
  assign status.elem_last = i_last && j_last;

  always_ff @(posedge clk) begin
    if (cmd.start_pass) begin
      m_run    <= m_cfg;
      k_run    <= k_cfg;
      n_run    <= n_cfg;
      i        <= '0;
      j        <= '0;
      t        <= '0;
      row_base <= '0;
      a_ptr    <= '0;
      b_ptr    <= '0;
    end else if (cmd.issue) begin
      t     <= t + IDX_W'(1);
      a_ptr <= a_ptr + ADDR_W'(1);
      b_ptr <= b_ptr + ADDR_W'(n_run);
    end else if (cmd.advance) begin
      t <= '0;
      if (j_last) begin
        j        <= '0;
        i        <= i + IDX_W'(1);
        row_base <= row_base_next;
        a_ptr    <= row_base_next;
        b_ptr    <= '0;
      end else begin
        j     <= j + IDX_W'(1);
        a_ptr <= row_base;
        b_ptr <= ADDR_W'(j) + ADDR_W'(1);
      end
    end
  end

  // Read, multiply, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_first <= (t == '0);
    s1_tlast <= t_last;
    s1_elast <= i_last && j_last;
    s1_row   <= i;
    s1_col   <= j;
    s2_first <= s1_first;
    s2_tlast <= s1_tlast;
    s2_elast <= s1_elast;
    s2_row   <= s1_row;
    s2_col   <= s1_col;
    s2_prod  <= $signed(left_rd) * $signed(right_rd);
  end

  assign prod_ext = {{(PROD_W - MUL_W){s2_prod[MUL_W-1]}}, s2_prod};
  assign acc_base = s2_first ? '0 : acc;
  assign acc_sum  = acc_base + prod_ext;
  assign landed   = s2_valid && s2_tlast;
  assign status.result_landed = landed;

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      acc <= acc_sum;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (landed) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (landed) begin
      out_product <= acc_sum;
      out_row     <= s2_row;
      out_col     <= s2_col;
      out_last    <= s2_elast;
    end
  end

  assign status.out_free = !out_valid || result.ready;

  assign result.valid   = out_valid;
  assign result.product = out_product;
  assign result.out_row = out_row;
  assign result.out_col = out_col;
  assign result.last    = out_last;

endmodule

// ===== hdl/matrix_multiply.sv =====
// Top level of the matrix multiply block: C = A x B over fixed-point elements.
//
//   channel   dir  handshake          payload
//   operand   in   valid/ready        action, value (Q8.8)
//   result    out  valid/ready        product (Q20.16), out_row, out_col, last
//   cfg       in   cfg_write          cfg_index, cfg_data
//
// Operand requests are taken only while idle; the one that completes both matrices
// starts a set-up step and then rows_a * cols_b products of inner_size steps each,
// through the single multiply-accumulate unit and the registered store reads.
// Synchronous reset clears sizes to 1 and both element counts.
// A stalled result holds in the output register and stops further issue.
module matrix_multiply import mm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  mm_in_if.sink                operand,
  mm_out_if.source             result
);

  mm_cmd_t    cmd;
  mm_status_t status;

  mm_controller u_controller (
    .clk      (clk),
    .rst      (rst),
    .in_valid (operand.valid),
    .in_ready (operand.ready),
    .cmd      (cmd),
    .status   (status)
  );

  mm_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .action    (operand.action),
    .value     (operand.value),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule
